### src/tro_pkg.sv
// ============================================================================
// tro_pkg
// Shared types and telnet codes for the receive-side option negotiator.
// ============================================================================
`default_nettype none

package tro_pkg;

   // Telnet command and option codes.
   localparam logic [7:0] T_IAC    = 8'd255;
   localparam logic [7:0] T_DONT   = 8'd254;
   localparam logic [7:0] T_DO     = 8'd253;
   localparam logic [7:0] T_WONT   = 8'd252;
   localparam logic [7:0] T_WILL   = 8'd251;
   localparam logic [7:0] T_EC     = 8'd247;
   localparam logic [7:0] T_AYT    = 8'd246;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;
   localparam logic [7:0] NUL_BYTE = 8'd0;
   localparam logic [7:0] BS_BYTE  = 8'd8;

   // Default depth of the job queue between front and back.
   localparam int JOB_QUEUE_DEPTH = 2;

   // Position of the last byte within a three-byte reply.
   localparam logic [1:0] REPLY_LAST = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       link_closed;
   } req_type;

   typedef struct packed {
      logic       to_remote;
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       local_echo_on;
      logic       raw_input_on;
      logic       session_closed;
   } rsp_type;

   // One unit of work for the back end: a single byte, or an IAC reply.
   typedef struct packed {
      logic       is_reply;
      logic       to_remote;
      logic [7:0] byte_a;      // single byte, or reply command
      logic [7:0] byte_b;      // reply option
      logic       remote_echoes;
      logic       closed;
   } job_type;

   // Queue handshake between the front end and the queue.
   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

   // Queue status and head seen by the back end.
   typedef struct packed {
      logic    empty;
      job_type head;
   } job_head_type;

endpackage

`default_nettype wire

### src/telnet_rx_option_negotiator.sv
// ============================================================================
// telnet_rx_option_negotiator
// Telnet receive-side IAC parser and option negotiator, queue interfaces.
// ============================================================================
// Usage. Received link bytes enter through a queue-like port: a transaction
// is taken when req_push is high and req_full is low. Results leave through
// a second queue-like port: the oldest result sits on rsp_data while
// rsp_empty is low, and is taken when rsp_pop is high.
// Each result is a console byte or a byte for the remote; last_of_run marks
// the final result caused by one input byte, and the echo, raw and closed
// flags reflect the state after that byte.
// A byte's job is written into the job queue when the byte is taken, and its
// first result is then registered in the back end's output register. Plain
// data flows at one byte per cycle while the receiver takes every result; an
// option request expands into a three-byte reply, which passes through the
// back end's single output register one byte at a time.
// The front end parses and updates state in the accepting cycle and writes
// at most one job into the queue; when it is full, req_full is raised.
// When the receiver stalls, the output register holds its result, the back
// end stops draining the queue and, once it fills, input is held off.
// A synchronous reset returns the parser to the plain data phase, clears
// all negotiation flags and discards every queued or waiting result.
// ============================================================================
`default_nettype none

module telnet_rx_option_negotiator #(
   parameter int QUEUE_DEPTH = tro_pkg::JOB_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire tro_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output tro_pkg::rsp_type      rsp_data
);

   // Job handshake from the front end, and the queue head seen by the back.
   tro_pkg::job_push_type job_wr;
   tro_pkg::job_head_type job_rd;
   logic                  job_pop;
   logic                  accept;

   // The front end may only take a byte when its job is sure to fit.
   assign accept = req_push && !req_full;

   tro_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .job_out (job_wr)
   );

   tro_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (job_wr),
      .full  (req_full),
      .pop   (job_pop),
      .rd    (job_rd)
   );

   // The back end walks through the bytes of each job one per cycle while results are taken.
   tro_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd        (job_rd),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### src/tro_front.sv
// ============================================================================
// tro_front
// Parses received bytes, keeps the negotiation state and issues jobs.
// ============================================================================
`default_nettype none

module tro_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire tro_pkg::req_type      req,
   output tro_pkg::job_push_type      job_out
);

   typedef enum logic [2:0] {
      PH_PLAIN = 3'd0,
      PH_IAC   = 3'd1,
      PH_WILL  = 3'd2,
      PH_DO    = 3'd3,
      PH_WONT  = 3'd4,
      PH_DONT  = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       echo_ff, echo_in;
   logic       rsga_ff, rsga_in;
   logic       lsga_ff, lsga_in;
   logic       closed_ff, closed_in;

   logic       emit;
   logic       is_reply;
   logic       to_remote;
   logic [7:0] byte_a;
   logic [7:0] byte_b;
   logic [7:0] b;

   assign b = req.rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      echo_in   = echo_ff;
      rsga_in   = rsga_ff;
      lsga_in   = lsga_ff;
      closed_in = closed_ff;
      emit      = 1'b0;
      is_reply  = 1'b0;
      to_remote = 1'b0;
      byte_a    = tro_pkg::NUL_BYTE;
      byte_b    = b;
      if (accept && !closed_ff) begin
         phase_in = PH_PLAIN;
         if (req.link_closed) begin
            closed_in = 1'b1;
            emit      = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_IAC: begin
                  if (b == tro_pkg::T_WILL) begin
                     phase_in = PH_WILL;
                  end else if (b == tro_pkg::T_DO) begin
                     phase_in = PH_DO;
                  end else if (b == tro_pkg::T_WONT) begin
                     phase_in = PH_WONT;
                  end else if (b == tro_pkg::T_DONT) begin
                     phase_in = PH_DONT;
                  end else if (b == tro_pkg::T_IAC) begin
                     emit   = 1'b1;
                     byte_a = tro_pkg::T_IAC;
                  end else if (b == tro_pkg::T_AYT) begin
                     emit      = 1'b1;
                     to_remote = 1'b1;
                     byte_a    = tro_pkg::NUL_BYTE;
                  end else if (b == tro_pkg::T_EC) begin
                     emit   = 1'b1;
                     byte_a = tro_pkg::BS_BYTE;
                  end
               end
               PH_WILL: begin
                  emit     = 1'b1;
                  is_reply = 1'b1;
                  if (b == tro_pkg::OPT_ECHO && !echo_ff) begin
                     byte_a  = tro_pkg::T_DO;
                     echo_in = 1'b1;
                  end else if (b == tro_pkg::OPT_SGA && !rsga_ff) begin
                     byte_a  = tro_pkg::T_DO;
                     rsga_in = 1'b1;
                  end else begin
                     byte_a = tro_pkg::T_DONT;
                  end
               end
               PH_DO: begin
                  emit     = 1'b1;
                  is_reply = 1'b1;
                  if (b == tro_pkg::OPT_SGA && !lsga_ff) begin
                     byte_a  = tro_pkg::T_WILL;
                     lsga_in = 1'b1;
                  end else begin
                     byte_a = tro_pkg::T_WONT;
                  end
               end
               PH_WONT: begin
                  byte_a = tro_pkg::T_DONT;
                  if (b == tro_pkg::OPT_ECHO) begin
                     if (echo_ff) begin
                        emit     = 1'b1;
                        is_reply = 1'b1;
                        echo_in  = 1'b0;
                     end
                  end else if (b == tro_pkg::OPT_SGA && rsga_ff) begin
                     emit     = 1'b1;
                     is_reply = 1'b1;
                     rsga_in  = 1'b0;
                  end
               end
               PH_DONT: begin
                  byte_a = tro_pkg::T_WONT;
                  if (b == tro_pkg::OPT_SGA && lsga_ff) begin
                     emit     = 1'b1;
                     is_reply = 1'b1;
                     lsga_in  = 1'b0;
                  end
               end
               default: begin
                  if (b == tro_pkg::T_IAC) begin
                     phase_in = PH_IAC;
                  end else begin
                     emit   = 1'b1;
                     byte_a = b;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      job_out.push              = emit;
      job_out.job.is_reply      = is_reply;
      job_out.job.to_remote     = to_remote | is_reply;
      job_out.job.byte_a        = byte_a;
      job_out.job.byte_b        = byte_b;
      job_out.job.remote_echoes = echo_in;
      job_out.job.closed        = closed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PLAIN;
         echo_ff   <= 1'b0;
         rsga_ff   <= 1'b0;
         lsga_ff   <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         echo_ff   <= echo_in;
         rsga_ff   <= rsga_in;
         lsga_ff   <= lsga_in;
         closed_ff <= closed_in;
      end
   end

endmodule

`default_nettype wire

### src/tro_job_queue.sv
// ============================================================================
// tro_job_queue
// Small first-in first-out queue of jobs between the front and back ends.
// ============================================================================
`default_nettype none

module tro_job_queue #(
   parameter int DEPTH = tro_pkg::JOB_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tro_pkg::job_push_type wr,
   output logic                       full,
   input  wire logic                  pop,
   output tro_pkg::job_head_type      rd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   tro_pkg::job_type  mem [DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [AW-1:0]     rptr_ff, rptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign rd.empty = (count_ff == '0);
   assign rd.head  = mem[rptr_ff];
   assign do_push  = wr.push && !full;
   assign do_pop   = pop && !rd.empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= wr.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/tro_back.sv
// ============================================================================
// tro_back
// Expands queued jobs into result transactions and holds the output register.
// ============================================================================
`default_nettype none

module tro_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tro_pkg::job_head_type rd,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output tro_pkg::rsp_type           rsp_data
);

   logic             valid_ff, valid_in;
   tro_pkg::rsp_type data_ff, data_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load;
   logic             last;
   tro_pkg::rsp_type item;

   assign load = !valid_ff || rsp_pop;
   assign last = !rd.head.is_reply || (idx_ff == tro_pkg::REPLY_LAST);

   always_comb begin
      item.to_remote      = rd.head.to_remote;
      item.last_of_run    = last;
      item.local_echo_on  = !rd.head.remote_echoes;
      item.raw_input_on   = rd.head.remote_echoes;
      item.session_closed = rd.head.closed;
      if (!rd.head.is_reply) begin
         item.out_byte = rd.head.byte_a;
      end else begin
         case (idx_ff)
            2'd0:    item.out_byte = tro_pkg::T_IAC;
            2'd1:    item.out_byte = rd.head.byte_a;
            default: item.out_byte = rd.head.byte_b;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      idx_in   = idx_ff;
      job_pop  = 1'b0;
      if (load && !rd.empty) begin
         valid_in = 1'b1;
         data_in  = item;
         if (last) begin
            job_pop = 1'b1;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

### src/tro_checker.sv
// ============================================================================
// tro_checker
// Port-level checks for the telnet receive-side option negotiator.
// ============================================================================
`default_nettype none

module tro_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire tro_pkg::rsp_type rsp_data
);

   // Reset leaves no result waiting and room for input.
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("result waiting or input blocked after reset");

   // A stalled result stays on the ports unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

   // Nothing follows the session-closed result.
   a_closed_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.session_closed) |=> rsp_empty)
      else $error("result after session closed");

   // Local echo and raw input are always opposite.
   a_echo_raw: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.local_echo_on != rsp_data.raw_input_on))
      else $error("echo and raw flags agree");

   // Only replies to the remote span several results.
   a_multi_remote: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last_of_run) |-> rsp_data.to_remote)
      else $error("non-final result not sent to remote");

endmodule

bind telnet_rx_option_negotiator tro_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
